// File: rtl/assert_macros.svh
// Assertion macros for the checker file dbl_chk.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CLK(lbl, !(cond))

`endif

// File: rtl/dbl_pkg.sv
// Shared types and codes of the degree bucket list.
// No dependencies.
package dbl_pkg;

  localparam logic [1:0] OpUpdate = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpGetMin = 2'd2;
  localparam logic [1:0] OpRead   = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StDegErr  = 2'd1;
  localparam logic [1:0] StNodeErr = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [9:0] node;
    logic [9:0] new_degree;
  } op_req_t;

  typedef struct packed {
    logic [9:0] result_node;
    logic [9:0] result_degree;
    logic       found;
    logic [1:0] status;
  } op_res_t;

endpackage

// File: rtl/dbl_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module dbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/dbl_ctrl.sv
// Operation sequencer: node memory (degree and links) and bucket head memory.
// Depends on dbl_pkg and dbl_ram.
module dbl_ctrl #(
  parameter int NODES = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [10:0]     act_i,
  input  logic            req_valid_i,
  input  dbl_pkg::op_req_t req_i,
  output logic            req_ready_o,
  output logic            res_valid_o,
  output dbl_pkg::op_res_t res_o,
  input  logic            res_ready_i
);
  import dbl_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int LW = AW + 1;
  localparam int NW = 10 + 2 * LW;
  localparam logic [LW-1:0] None = LW'(NODES);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_N0, S_N1, S_N2, S_N3, S_N4, S_N5, S_P1, S_P2, S_SCAN, S_GM, S_FIN
  } state_e;

  typedef struct packed {
    logic [9:0]    deg;
    logic [LW-1:0] nx;
    logic [LW-1:0] pv;
  } nent_t;

  state_e        state_q, state_d;
  op_req_t       op_q, op_d;
  nent_t         cur_q, cur_d;
  logic [LW-1:0] hd_q, hd_d;
  logic [LW-1:0] clr_q, clr_d;
  logic [10:0]   sc_q, sc_d;
  logic          pend_q, pend_d;
  logic [9:0]    mark_q, mark_d;
  op_res_t       res_q, res_d;

  logic          n_we, n_re, h_we, h_re;
  logic [AW-1:0] n_waddr, n_raddr, h_waddr, h_raddr;
  logic [NW-1:0] n_wdata, n_rdata;
  logic [LW-1:0] h_wdata, h_rdata;
  nent_t         nrd, nwr;
  logic [AW-1:0] self_idx;

  assign nrd      = nent_t'(n_rdata);
  assign n_wdata  = NW'(nwr);
  assign self_idx = AW'(op_q.node);

  dbl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_ram (
    .clk_i, .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .re_i(n_re), .raddr_i(n_raddr), .rdata_o(n_rdata)
  );

  dbl_ram #(.WIDTH(LW), .DEPTH(NODES)) u_head_ram (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .re_i(h_re), .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cur_d   = cur_q;
    hd_d    = hd_q;
    clr_d   = clr_q;
    sc_d    = sc_q;
    pend_d  = pend_q;
    mark_d  = mark_q;
    res_d   = res_q;
    n_we    = 1'b0;
    n_re    = 1'b0;
    h_we    = 1'b0;
    h_re    = 1'b0;
    n_waddr = self_idx;
    n_raddr = self_idx;
    h_waddr = AW'(cur_q.deg);
    h_raddr = AW'(cur_q.deg);
    nwr     = '{deg: cur_q.deg, nx: None, pv: None};
    h_wdata = None;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_CLR: begin
        n_we    = 1'b1;
        n_waddr = AW'(clr_q);
        nwr     = '{deg: 10'd0, nx: None, pv: None};
        h_we    = 1'b1;
        h_waddr = AW'(clr_q);
        clr_d   = clr_q + LW'(1);
        if (clr_q == LW'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d  = req_i;
          res_d = '{result_node: req_i.node, result_degree: 10'd0, found: 1'b0,
                    status: StOk};
          if (req_i.operation == OpGetMin) begin
            sc_d    = {1'b0, mark_q};
            pend_d  = 1'b0;
            state_d = S_SCAN;
          end else if ({1'b0, req_i.node} >= act_i) begin
            res_d.status = StNodeErr;
            state_d      = S_FIN;
          end else if (req_i.operation == OpUpdate && {1'b0, req_i.new_degree} >= act_i) begin
            res_d.status = StDegErr;
            state_d      = S_FIN;
          end else begin
            if (req_i.operation == OpUpdate && req_i.new_degree < mark_q) begin
              mark_d = req_i.new_degree;
            end
            state_d = S_N0;
          end
        end
      end
      S_N0: begin
        n_re    = 1'b1;
        state_d = S_N1;
      end
      S_N1: begin
        cur_d = nrd;
        if (op_q.operation == OpRead) begin
          res_d.result_degree = nrd.deg;
          state_d = S_FIN;
        end else begin
          h_re    = 1'b1;
          h_raddr = AW'(nrd.deg);
          state_d = S_N2;
        end
      end
      S_N2: begin
        // The node is the bucket head: the head moves to its successor.
        if (h_rdata == LW'(op_q.node)) begin
          h_we    = 1'b1;
          h_wdata = cur_q.nx;
        end
        if (cur_q.nx != None) begin
          n_re    = 1'b1;
          n_raddr = AW'(cur_q.nx);
        end
        state_d = S_N3;
      end
      S_N3: begin
        if (cur_q.nx != None) begin
          n_we    = 1'b1;
          n_waddr = AW'(cur_q.nx);
          nwr     = '{deg: nrd.deg, nx: nrd.nx, pv: cur_q.pv};
        end
        if (cur_q.pv != None) begin
          n_re    = 1'b1;
          n_raddr = AW'(cur_q.pv);
        end
        state_d = S_N4;
      end
      S_N4: begin
        if (cur_q.pv != None) begin
          n_we    = 1'b1;
          n_waddr = AW'(cur_q.pv);
          nwr     = '{deg: nrd.deg, nx: cur_q.nx, pv: nrd.pv};
        end
        state_d = S_N5;
      end
      S_N5: begin
        if (op_q.operation == OpRemove) begin
          n_we    = 1'b1;
          nwr     = '{deg: cur_q.deg, nx: None, pv: None};
          res_d.result_degree = cur_q.deg;
          state_d = S_FIN;
        end else begin
          h_re    = 1'b1;
          h_raddr = AW'(op_q.new_degree);
          state_d = S_P1;
        end
      end
      S_P1: begin
        hd_d    = h_rdata;
        h_we    = 1'b1;
        h_waddr = AW'(op_q.new_degree);
        h_wdata = LW'(op_q.node);
        n_we    = 1'b1;
        nwr     = '{deg: op_q.new_degree, nx: h_rdata, pv: None};
        if (h_rdata != None) begin
          n_re    = 1'b1;
          n_raddr = AW'(h_rdata);
        end
        state_d = S_P2;
      end
      S_P2: begin
        if (hd_q != None) begin
          n_we    = 1'b1;
          n_waddr = AW'(hd_q);
          nwr     = '{deg: nrd.deg, nx: nrd.nx, pv: LW'(op_q.node)};
        end
        res_d.result_degree = op_q.new_degree;
        state_d = S_FIN;
      end
      S_SCAN: begin
        // Head reads are issued back to back; each is checked in the following cycle.
        if (pend_q && h_rdata != None) begin
          hd_d    = h_rdata;
          n_re    = 1'b1;
          n_raddr = AW'(h_rdata);
          state_d = S_GM;
        end else if (sc_q < act_i) begin
          h_re    = 1'b1;
          h_raddr = AW'(sc_q);
          sc_d    = sc_q + 11'd1;
          pend_d  = 1'b1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_GM: begin
        res_d.result_node   = 10'(hd_q);
        res_d.result_degree = nrd.deg;
        res_d.found         = 1'b1;
        state_d             = S_FIN;
      end
      S_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      mark_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      mark_q  <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    cur_q <= cur_d;
    hd_q  <= hd_d;
    sc_q  <= sc_d;
    res_q <= res_d;
  end

endmodule

// File: rtl/degree_bucket_list_core.sv
// Top level of the degree bucket list: stream ports, size register, result register.
// Depends on dbl_pkg and dbl_ctrl.
//
//  channel   direction  carries
//  s_axis    in         one operation request
//  m_axis    out        one result per request
//  cfg       in         active node count (11 bits)
//
// Reset starts a clearing pass over every entry of both memories; no request
// is taken during it. Read degree, remove and update run through a sequence of
// states set by the single read and write port of the node memory; errors go
// straight to the result. Get-min scans the bucket heads, one head read a cycle.
// A request is taken while the previous result waits in the output register.
module degree_bucket_list_core #(
  parameter int NODES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // operation[1:0], node[11:2], new_degree[21:12], zeros[23:22]
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_node[9:0], result_degree[19:10], status[21:20], zeros[23:22]
  output logic [23:0] m_axis_tdata_o,
  // found[0]
  output logic        m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);
  import dbl_pkg::*;

  localparam int ActCap = (NODES < 2047) ? NODES : 2047;

  logic [10:0] act_q, act;
  op_req_t     req;
  op_res_t     res;
  logic        res_valid, res_ready;
  logic        m_valid_q;
  op_res_t     m_res_q;

  assign cfg_ready_o = 1'b1;
  assign act = (act_q > 11'(ActCap)) ? 11'(ActCap) : act_q;

  assign req = '{operation: s_axis_tdata_i[1:0], node: s_axis_tdata_i[11:2],
                 new_degree: s_axis_tdata_i[21:12]};

  dbl_ctrl #(.NODES(NODES)) u_ctrl (
    .clk_i, .rst_ni, .act_i(act),
    .req_valid_i(s_axis_tvalid_i), .req_i(req), .req_ready_o(s_axis_tready_o),
    .res_valid_o(res_valid), .res_o(res), .res_ready_i(res_ready)
  );

  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 11'd1024;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        act_q <= cfg_data_i;
      end
      if (res_ready) begin
        m_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, m_res_q.status, m_res_q.result_degree,
                            m_res_q.result_node};
  assign m_axis_tuser_o  = m_res_q.found;

endmodule

// File: rtl/dbl_chk.sv
// Port-level checker for degree_bucket_list_core, bound to the top level.
// Depends on assert_macros.svh and dbl_pkg.
`include "assert_macros.svh"

module dbl_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);
  import dbl_pkg::*;

  `ASSERT_CLK(a_valid_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
  `ASSERT_CLK(a_data_hold, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
  `ASSERT_CLK(a_found_ok, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[21:20] == StOk)
  `ASSERT_CLK(a_err_nodeg,
              m_axis_tvalid_o && m_axis_tdata_o[21:20] != StOk |-> m_axis_tdata_o[19:10] == 10'd0)
  `ASSERT_NEVER(a_bad_status, m_axis_tvalid_o && m_axis_tdata_o[21:20] == 2'd3)

endmodule

bind degree_bucket_list_core dbl_chk u_dbl_chk (
  .clk_i, .rst_ni, .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
);
